FILE: rtl/core/scacc_pkg.sv
// Shared types and constants for the sparse coordinate accumulator.
package scacc_pkg;

   localparam int DefaultEntryCapacity = 256;
   localparam int DefaultIndexBits     = 16;
   localparam int PortCoordBits        = 16;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic                     valid;
      logic                     add;
      logic [PortCoordBits-1:0] row;
      logic [PortCoordBits-1:0] col;
      logic signed [31:0]       quantity;
      logic signed [31:0]       value;
      logic                     found;
      logic                     done;
   } token_type;

endpackage

FILE: rtl/core/scacc_cell.sv
// One table entry of the accumulator chain with its token stage.
module scacc_cell
   import scacc_pkg::*;
#(
   parameter int COORD_BITS = DefaultIndexBits
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type tok_in,
   output token_type tok_out,
   output logic      occupied
);

   logic                  ent_valid_ff, ent_valid_in;
   logic [COORD_BITS-1:0] ent_row_ff, ent_col_ff;
   logic signed [31:0]    ent_value_ff, ent_value_in;
   token_type             tok_ff, tok_in_next;
   logic                  hit, claim;
   logic signed [31:0]    sum;

   assign hit   = tok_in.valid && ent_valid_ff && !tok_in.done
                  && (tok_in.row[COORD_BITS-1:0] == ent_row_ff)
                  && (tok_in.col[COORD_BITS-1:0] == ent_col_ff);
   assign claim = tok_in.valid && !ent_valid_ff && !tok_in.done;
   assign sum   = ent_value_ff + tok_in.quantity;

   always_comb begin
      tok_in_next  = tok_in;
      ent_valid_in = ent_valid_ff;
      ent_value_in = ent_value_ff;
      if (hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.done  = 1'b1;
         if (tok_in.add) begin
            tok_in_next.value = sum;
            ent_value_in      = sum;
         end else begin
            tok_in_next.value = ent_value_ff;
         end
      end else if (claim) begin
         tok_in_next.found = 1'b0;
         tok_in_next.done  = 1'b1;
         if (tok_in.add) begin
            tok_in_next.value = tok_in.quantity;
            ent_value_in      = tok_in.quantity;
            ent_valid_in      = 1'b1;
         end else begin
            tok_in_next.value = 32'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         tok_ff       <= '0;
      end else if (advance) begin
         ent_valid_ff <= ent_valid_in;
         tok_ff       <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ent_value_ff <= ent_value_in;
         if (claim && tok_in.add) begin
            ent_row_ff <= tok_in.row[COORD_BITS-1:0];
            ent_col_ff <= tok_in.col[COORD_BITS-1:0];
         end
      end
   end

   assign tok_out  = tok_ff;
   assign occupied = ent_valid_ff;

endmodule

FILE: rtl/core/sparse_coordinate_accumulator_top.sv
// Top level of the sparse coordinate accumulator: entry cell chain and result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | action, row_index, col_index, quantity
//   rsp     | out       | rsp_valid / rsp_stall | value, found, table_full
//
// One word enters per cycle while no result is stalled; its result passes through
// the cell chain and then the result register.
// Reset empties the table at once; every cell's occupied flag clears.
// A stalled result holds the whole chain and stalls the request side.
module sparse_coordinate_accumulator_top
   import scacc_pkg::*;
#(
   parameter int ENTRY_CAPACITY = DefaultEntryCapacity,
   parameter int INDEX_BITS     = DefaultIndexBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [15:0]        req_row_index,
   input  logic [15:0]        req_col_index,
   input  logic signed [31:0] req_quantity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_found,
   output logic               rsp_table_full
);

   localparam int CoordBits = (INDEX_BITS < PortCoordBits) ? INDEX_BITS : PortCoordBits;

   token_type                 tok_chain [0:ENTRY_CAPACITY];
   token_type                 head;
   logic [ENTRY_CAPACITY-1:0] occupied;
   logic                      advance;
   logic                      rsp_valid_ff;
   logic signed [31:0]        rsp_value_ff;
   logic                      rsp_found_ff, rsp_table_full_ff;
   token_type                 last;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head          = '0;
      head.valid    = req_valid;
      head.add      = (req_action == ACT_ADD);
      head.row      = PortCoordBits'(req_row_index[CoordBits-1:0]);
      head.col      = PortCoordBits'(req_col_index[CoordBits-1:0]);
      head.quantity = req_quantity;
      head.value    = 32'sd0;
   end

   assign tok_chain[0] = head;

   for (genvar i = 0; i < ENTRY_CAPACITY; i++) begin : g_cell
      scacc_cell #(
         .COORD_BITS(CoordBits)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .tok_in   (tok_chain[i]),
         .tok_out  (tok_chain[i+1]),
         .occupied (occupied[i])
      );
   end

   assign last = tok_chain[ENTRY_CAPACITY];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff      <= last.done ? last.value : 32'sd0;
         rsp_found_ff      <= last.found && last.done;
         rsp_table_full_ff <= !last.done && last.add;
      end
   end

   assign req_stall      = !advance;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_table_full = rsp_table_full_ff;

   a_full_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_table_full))
      else $error("found and table_full both set");

   a_full_only_when_filled : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> occupied[ENTRY_CAPACITY-1])
      else $error("table_full with free entries");

   a_fill_in_order : assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, occupied} + {{ENTRY_CAPACITY{1'b0}}, 1'b1}))
      else $error("entries not filled in order");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(occupied))
      else $error("table changed while stalled");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sparse coordinate accumulator top level.
`timescale 1ns / 100ps

module testbench
   import scacc_pkg::*;
();

   localparam int TableDepth = DefaultEntryCapacity;
   localparam int ChainLatency = TableDepth + 1;
   localparam int HotCount = 48;
   localparam int RandomWords = 790;

   typedef struct {
      logic signed [31:0] value;
      logic               found;
      logic               table_full;
   } cell_result_type;

   class coo_ledger;
      logic [15:0]        cell_row [TableDepth];
      logic [15:0]        cell_col [TableDepth];
      logic signed [31:0] cell_value [TableDepth];
      int                 cell_count;
      cell_result_type    pending [$];
      int                 errors;
      int                 checked;

      function new();
         cell_count = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void note_request(input logic act, input logic [15:0] row,
                                 input logic [15:0] col, input logic signed [31:0] qty);
         cell_result_type want;
         int              slot;
         int              i;
         slot = -1;
         want.value = 32'sd0;
         want.found = 1'b0;
         want.table_full = 1'b0;
         for (i = 0; i < cell_count; i++) begin
            if (slot < 0 && cell_row[i] == row && cell_col[i] == col) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            want.found = 1'b1;
            if (act == ACT_ADD) begin
               cell_value[slot] = cell_value[slot] + qty;
            end
            want.value = cell_value[slot];
         end else if (act == ACT_ADD) begin
            if (cell_count < TableDepth) begin
               cell_row[cell_count] = row;
               cell_col[cell_count] = col;
               cell_value[cell_count] = qty;
               cell_count++;
               want.value = qty;
            end else begin
               want.table_full = 1'b1;
            end
         end
         pending = {pending, want};
      endfunction

      function void check_result(input logic signed [31:0] value, input logic found,
                                 input logic table_full);
         cell_result_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%0d found=%0b table_full=%0b",
                     $time, value, found, table_full);
            errors++;
         end else begin
            want = pending.pop_front();
            if (value !== want.value) begin
               $display("%0t: value expected %0d actual %0d", $time, want.value, value);
               errors++;
            end
            if (found !== want.found) begin
               $display("%0t: found expected %0b actual %0b", $time, want.found, found);
               errors++;
            end
            if (table_full !== want.table_full) begin
               $display("%0t: table_full expected %0b actual %0b",
                        $time, want.table_full, table_full);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = ACT_ADD;
   logic [15:0]        req_row_index = '0;
   logic [15:0]        req_col_index = '0;
   logic signed [31:0] req_quantity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_found;
   logic               rsp_table_full;

   coo_ledger   ledger = new();
   logic [15:0] hot_row [HotCount];
   logic [15:0] hot_col [HotCount];

   sparse_coordinate_accumulator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_quantity   (req_quantity),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_found      (rsp_found),
      .rsp_table_full (rsp_table_full)
   );

   always #4 clock = ~clock;

   task automatic send_word(input logic act, input logic [15:0] row, input logic [15:0] col,
                            input logic signed [31:0] qty);
      @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_row_index <= row;
      req_col_index <= col;
      req_quantity <= qty;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_request(act, row, col, qty);
   endtask

   task automatic pause_req(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [31:0] pick_quantity();
      case ($urandom_range(0, 19))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3: return 32'sd0;
         4: return 32'sd1;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         ledger.check_result(rsp_value, rsp_found, rsp_table_full);
      end
   end

   initial begin
      bit held_off;
      int pick;
      held_off = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (!held_off && ledger.checked >= 150) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (3 * ChainLatency) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               rsp_stall <= 1'b0;
               repeat (100) @(negedge clock);
            end else if (pick < 70) begin
               rsp_stall <= 1'b0;
            end else if (pick < 96) begin
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 60)) @(negedge clock);
            end
         end
      end
   end

   initial begin
      int          i;
      int          pick;
      logic        act;
      logic [15:0] row;
      logic [15:0] col;
      for (i = 0; i < HotCount; i++) begin
         hot_row[i] = $urandom;
         hot_col[i] = $urandom;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(ACT_ADD, 16'h0000, 16'h0000, 32'sh7FFF_FFFF);
      send_word(ACT_ADD, 16'h0000, 16'h0000, 32'sd1);
      send_word(ACT_READ, 16'h0000, 16'h0000, 32'sd0);
      send_word(ACT_READ, 16'hFFFF, 16'hFFFF, 32'sd0);
      send_word(ACT_ADD, 16'hFFFF, 16'hFFFF, 32'sh8000_0000);
      send_word(ACT_ADD, 16'hFFFF, 16'hFFFF, -32'sd1);
      send_word(ACT_READ, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF);
      send_word(ACT_ADD, 16'h0000, 16'hFFFF, 32'sd0);
      send_word(ACT_ADD, 16'hFFFF, 16'h0000, -32'sd1);
      send_word(ACT_READ, 16'h0000, 16'hFFFF, 32'sd0);
      send_word(ACT_READ, 16'hFFFF, 16'h0000, 32'sd0);
      send_word(ACT_READ, 16'h0000, 16'h0000, 32'sh5A5A_A5A5);
      send_word(ACT_READ, 16'h1234, 16'h4321, -32'sd1);
      send_word(ACT_ADD, 16'hAAAA, 16'h5555, 32'sh5555_AAAA);
      send_word(ACT_ADD, 16'h5555, 16'hAAAA, 32'shAAAA_5555);

      for (i = 0; i < RandomWords; i++) begin
         act = ($urandom_range(0, 99) < 70) ? ACT_ADD : ACT_READ;
         pick = $urandom_range(0, 99);
         if ((act == ACT_ADD && pick < 50) || (act == ACT_READ && pick < 20)) begin
            row = $urandom;
            col = $urandom;
         end else begin
            pick = $urandom_range(0, HotCount - 1);
            row = hot_row[pick];
            col = hot_col[pick];
         end
         send_word(act, row, col, pick_quantity());
         if (i % 200 >= 40) begin
            pause_req(gap_length());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (ChainLatency + 40) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
